FILE: hdl/ilnf_pkg.sv
// ----------------------------------------------------------------------------
// ilnf_pkg
// Shared constants, types and tag helpers for the next-fit heap allocator.
// ----------------------------------------------------------------------------
package ilnf_pkg;

  localparam int unsigned HEAP_BYTES  = 65536;
  localparam int unsigned CHUNK_BYTES = 4096;
  localparam int unsigned WSIZE       = 4;
  localparam int unsigned DSIZE       = 8;
  localparam int unsigned MIN_BLOCK   = 2 * DSIZE;
  localparam int unsigned LIST_START  = 8;
  localparam int unsigned WORDS       = HEAP_BYTES / WSIZE;
  localparam int unsigned AW          = $clog2(WORDS);
  localparam int unsigned WALK_LIMIT  = HEAP_BYTES / 8 + 2;
  localparam int unsigned NW          = $clog2(WALK_LIMIT + 1);
  localparam int unsigned TOPW        = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned ASZW        = 17;

  typedef logic [31:0]   word_t;
  typedef logic [AW-1:0] waddr_t;

  typedef struct packed {
    logic   en;
    logic   we;
    waddr_t addr;
    word_t  wdata;
  } mem_req_t;

  // byte address outside the word array: reads give 0, writes are dropped
  function automatic logic is_oob(word_t a);
    return a >= word_t'(HEAP_BYTES);
  endfunction

  function automatic word_t size_of(word_t v);
    return v & ~word_t'(32'h7);
  endfunction

  // size field seen when reading back a tag just written at a
  function automatic word_t rb_size(word_t a, word_t v);
    return is_oob(a) ? '0 : size_of(v);
  endfunction

  // heap image after reset: prologue, one free chunk, epilogue
  function automatic word_t init_word(waddr_t i);
    word_t b;
    b = word_t'(i) << 2;
    if (b == word_t'(WSIZE) || b == word_t'(DSIZE)) return word_t'(32'h9);
    else if (b == word_t'(LIST_START + WSIZE)) return word_t'(CHUNK_BYTES);
    else if (b == word_t'(LIST_START + CHUNK_BYTES)) return word_t'(CHUNK_BYTES);
    else if (b == word_t'(LIST_START + WSIZE + CHUNK_BYTES)) return word_t'(32'h1);
    else return '0;
  endfunction

endpackage

FILE: hdl/implicit_list_next_fit_allocator.sv
// ----------------------------------------------------------------------------
// implicit_list_next_fit_allocator
// Boundary-tag heap allocator with next-fit search over a 16K-word store.
// ----------------------------------------------------------------------------
//  channel  ports                                      direction
//  in       in_valid/in_ready, in_mode, in_req_size,   request in
//           in_block_addr
//  out      out_valid/out_ready, out_payload_addr,     result out
//           out_ok
//
// After reset the heap store is swept once, one word a cycle, with in_ready
// low. An allocate reads the rover header, walks block headers from the
// rover (then in a wrap pass from the heap start), places the block and may
// first grow the heap and coalesce; a zero-size allocate or an ignored free
// goes straight to its result. Every step is a single read or write on the
// single store port. A result waits in the output register while the next
// request is taken.
module implicit_list_next_fit_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_payload_addr,
  output logic        out_ok
);
  import ilnf_pkg::*;

  mem_req_t mreq;
  word_t    rdata;

  ilnf_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_req_size      (in_req_size),
    .in_block_addr    (in_block_addr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_addr (out_payload_addr),
    .out_ok           (out_ok),
    .mreq             (mreq),
    .rdata            (rdata)
  );

  ilnf_ram u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

endmodule

FILE: hdl/ilnf_ram.sv
// ----------------------------------------------------------------------------
// ilnf_ram
// Single-port heap word store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ilnf_ram (
  input  logic              clk,
  input  ilnf_pkg::mem_req_t req,
  output ilnf_pkg::word_t   rdata
);
  import ilnf_pkg::*;

  word_t mem [WORDS];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

FILE: hdl/ilnf_ctrl.sv
// ----------------------------------------------------------------------------
// ilnf_ctrl
// Request sequencer: next-fit walk, split, heap growth and coalescing, all as
// single read or write steps against the heap store.
// ----------------------------------------------------------------------------
module ilnf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [15:0]        in_req_size,
  input  logic [15:0]        in_block_addr,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_payload_addr,
  output logic               out_ok,
  output ilnf_pkg::mem_req_t mreq,
  input  ilnf_pkg::word_t    rdata
);
  import ilnf_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_F_HDR, ST_F_FTR,
    ST_S1, ST_SL, ST_W0, ST_W1, ST_W2,
    ST_G0, ST_G1, ST_G2,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_MA1, ST_MB1, ST_MB2,
    ST_MC1, ST_MC2, ST_MC3, ST_MC4, ST_MC5, ST_MC6, ST_MEND,
    ST_P1, ST_PS2, ST_PS3, ST_PS4, ST_PN2, ST_DONE
  } state_t;

  state_t          state_r, state_nxt;
  word_t           bp_r, bp_nxt, p_r, p_nxt, t_r, t_nxt;
  word_t           sz_r, sz_nxt, bsz_r, bsz_nxt, ps_r, ps_nxt;
  word_t           rov_r, rov_nxt;
  logic [ASZW-1:0] asz_r, asz_nxt;
  logic [TOPW-1:0] top_r, top_nxt;
  logic [NW-1:0]   n_r, n_nxt, n_inc;
  logic            pa_r, pa_nxt, grow_r, grow_nxt;
  logic [15:0]     res_addr_r, res_addr_nxt;
  logic            res_ok_r, res_ok_nxt;
  waddr_t          clr_r, clr_nxt;
  logic            rd_oob_r, rd_oob_nxt;
  logic            out_valid_r, out_valid_nxt, out_ok_r, out_ok_nxt;
  logic [15:0]     out_addr_r, out_addr_nxt;

  word_t       q, qs, ma, wd, asz, ext, gsz, csub;
  logic        m_rd, m_wr, fits, split;
  logic [16:0] rsum;
  logic [32:0] gsum;

  assign q     = rd_oob_r ? '0 : rdata;
  assign qs    = size_of(q);
  assign asz   = word_t'(asz_r);
  assign fits  = !q[0] && (qs >= asz);
  assign n_inc = n_r + NW'(1);
  assign rsum  = 17'(in_req_size) + 17'(15);
  assign ext   = (asz > word_t'(CHUNK_BYTES)) ? asz : word_t'(CHUNK_BYTES);
  assign gsz   = ((ext >> 2) + word_t'(ext[2])) << 2;
  assign gsum  = 33'(top_r) + 33'(gsz);
  assign split = (qs >= asz) && ((qs - asz) >= word_t'(MIN_BLOCK));
  assign csub  = p_r - asz;

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_payload_addr = out_addr_r;
  assign out_ok           = out_ok_r;

  always_comb begin
    state_nxt = state_r; bp_nxt = bp_r; p_nxt = p_r; t_nxt = t_r;
    sz_nxt = sz_r; bsz_nxt = bsz_r; ps_nxt = ps_r; rov_nxt = rov_r;
    asz_nxt = asz_r; top_nxt = top_r; n_nxt = n_r; pa_nxt = pa_r;
    grow_nxt = grow_r; res_addr_nxt = res_addr_r; res_ok_nxt = res_ok_r;
    clr_nxt = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt = out_addr_r; out_ok_nxt = out_ok_r;
    ma = '0; wd = '0; m_rd = 1'b0; m_wr = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            res_addr_nxt = '0; res_ok_nxt = 1'b1; state_nxt = ST_DONE;
            if (in_block_addr[2:0] == 3'd0 &&
                in_block_addr >= 16'(LIST_START + DSIZE) &&
                TOPW'(in_block_addr) < top_r) begin
              bp_nxt = word_t'(in_block_addr); grow_nxt = 1'b0;
              ma = word_t'(in_block_addr) - word_t'(WSIZE); m_rd = 1'b1;
              state_nxt = ST_F_HDR;
            end
          end else if (in_req_size == 16'd0) begin
            res_addr_nxt = '0; res_ok_nxt = 1'b0; state_nxt = ST_DONE;
          end else begin
            asz_nxt = (in_req_size <= 16'(DSIZE)) ? ASZW'(MIN_BLOCK) : {rsum[16:3], 3'b000};
            ma = rov_r - word_t'(WSIZE); m_rd = 1'b1;
            state_nxt = ST_S1;
          end
        end
      end
      ST_F_HDR: begin
        sz_nxt = qs; ma = bp_r - word_t'(WSIZE); wd = qs; m_wr = 1'b1;
        state_nxt = ST_F_FTR;
      end
      ST_F_FTR: begin
        ma = bp_r + sz_r - word_t'(DSIZE); wd = sz_r; m_wr = 1'b1;
        state_nxt = ST_M0;
      end
      // next-fit walk from the block after the rover up to the epilogue
      ST_S1: begin
        bp_nxt = rov_r + qs; n_nxt = '0;
        ma = rov_r + qs - word_t'(WSIZE); m_rd = 1'b1;
        state_nxt = ST_SL;
      end
      ST_SL: begin
        if (qs == '0) begin
          state_nxt = ST_W0;
        end else if (fits) begin
          rov_nxt = bp_r; res_addr_nxt = bp_r[15:0]; res_ok_nxt = 1'b1;
          ma = bp_r - word_t'(WSIZE); m_rd = 1'b1; state_nxt = ST_P1;
        end else begin
          bp_nxt = bp_r + qs; n_nxt = n_inc;
          if (n_inc < NW'(WALK_LIMIT)) begin
            ma = bp_r + qs - word_t'(WSIZE); m_rd = 1'b1;
          end else begin
            state_nxt = ST_W0;
          end
        end
      end
      // wrap pass from the heap start up to the rover
      ST_W0: begin
        n_nxt = '0; bp_nxt = word_t'(LIST_START);
        if (word_t'(LIST_START) < rov_r) begin
          ma = word_t'(LIST_START - WSIZE); m_rd = 1'b1; state_nxt = ST_W1;
        end else begin
          state_nxt = ST_G0;
        end
      end
      ST_W1: begin
        bp_nxt = bp_r + qs; ma = bp_r + qs - word_t'(WSIZE); m_rd = 1'b1;
        state_nxt = ST_W2;
      end
      ST_W2: begin
        if (qs == '0) begin
          state_nxt = ST_G0;
        end else if (fits) begin
          rov_nxt = bp_r; res_addr_nxt = bp_r[15:0]; res_ok_nxt = 1'b1;
          ma = bp_r - word_t'(WSIZE); m_rd = 1'b1; state_nxt = ST_P1;
        end else begin
          n_nxt = n_inc;
          if (n_inc < NW'(WALK_LIMIT) && bp_r < rov_r) begin
            bp_nxt = bp_r + qs; ma = bp_r + qs - word_t'(WSIZE); m_rd = 1'b1;
          end else begin
            state_nxt = ST_G0;
          end
        end
      end
      ST_G0: begin
        if (gsum > 33'(HEAP_BYTES)) begin
          res_addr_nxt = '0; res_ok_nxt = 1'b0; state_nxt = ST_DONE;
        end else begin
          top_nxt = TOPW'(gsum); bp_nxt = word_t'(top_r); sz_nxt = gsz;
          grow_nxt = 1'b1;
          ma = word_t'(top_r) - word_t'(WSIZE); wd = gsz; m_wr = 1'b1;
          state_nxt = ST_G1;
        end
      end
      ST_G1: begin
        ma = bp_r + sz_r - word_t'(DSIZE); wd = sz_r; m_wr = 1'b1;
        state_nxt = ST_G2;
      end
      ST_G2: begin
        ma = bp_r + sz_r - word_t'(WSIZE); wd = word_t'(32'h1); m_wr = 1'b1;
        state_nxt = ST_M0;
      end
      // coalesce: gather neighbor tags
      ST_M0: begin
        ma = bp_r - word_t'(DSIZE); m_rd = 1'b1; state_nxt = ST_M1;
      end
      ST_M1: begin
        p_nxt = bp_r - qs; ma = bp_r - qs - word_t'(WSIZE); m_rd = 1'b1;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        ps_nxt = qs; ma = p_r + qs - word_t'(DSIZE); m_rd = 1'b1;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        pa_nxt = q[0]; ma = bp_r - word_t'(WSIZE); m_rd = 1'b1;
        state_nxt = ST_M4;
      end
      ST_M4: begin
        bsz_nxt = qs; ma = bp_r + qs - word_t'(WSIZE); m_rd = 1'b1;
        state_nxt = ST_M5;
      end
      ST_M5: begin
        priority if (pa_r && q[0]) begin
          state_nxt = ST_MEND;
        end else if (pa_r) begin
          sz_nxt = bsz_r + qs; ma = bp_r - word_t'(WSIZE); wd = bsz_r + qs;
          m_wr = 1'b1; state_nxt = ST_MA1;
        end else if (q[0]) begin
          sz_nxt = bsz_r + ps_r; ma = bp_r + bsz_r - word_t'(DSIZE);
          wd = bsz_r + ps_r; m_wr = 1'b1; state_nxt = ST_MB1;
        end else begin
          ma = bp_r + bsz_r + qs - word_t'(DSIZE); m_rd = 1'b1;
          state_nxt = ST_MC1;
        end
      end
      ST_MA1: begin
        ma = bp_r + rb_size(bp_r - word_t'(WSIZE), sz_r) - word_t'(DSIZE);
        wd = sz_r; m_wr = 1'b1; state_nxt = ST_MEND;
      end
      ST_MB1: begin
        ma = bp_r - word_t'(DSIZE); m_rd = 1'b1; state_nxt = ST_MB2;
      end
      ST_MB2: begin
        bp_nxt = bp_r - qs; ma = bp_r - qs - word_t'(WSIZE); wd = sz_r;
        m_wr = 1'b1; state_nxt = ST_MEND;
      end
      ST_MC1: begin
        sz_nxt = bsz_r + ps_r + qs; ma = p_r - word_t'(WSIZE);
        wd = bsz_r + ps_r + qs; m_wr = 1'b1; state_nxt = ST_MC2;
      end
      ST_MC2: begin
        ma = bp_r - word_t'(WSIZE); m_rd = 1'b1; state_nxt = ST_MC3;
      end
      ST_MC3: begin
        t_nxt = bp_r + qs; ma = bp_r + qs - word_t'(WSIZE); m_rd = 1'b1;
        state_nxt = ST_MC4;
      end
      ST_MC4: begin
        ma = t_r + qs - word_t'(DSIZE); wd = sz_r; m_wr = 1'b1;
        state_nxt = ST_MC5;
      end
      ST_MC5: begin
        ma = bp_r - word_t'(DSIZE); m_rd = 1'b1; state_nxt = ST_MC6;
      end
      ST_MC6: begin
        bp_nxt = bp_r - qs; state_nxt = ST_MEND;
      end
      ST_MEND: begin
        rov_nxt = bp_r;
        if (grow_r) begin
          res_addr_nxt = bp_r[15:0]; res_ok_nxt = 1'b1;
          ma = bp_r - word_t'(WSIZE); m_rd = 1'b1; state_nxt = ST_P1;
        end else begin
          res_addr_nxt = '0; res_ok_nxt = 1'b1; state_nxt = ST_DONE;
        end
      end
      // place: split when the remainder can hold a minimum block
      ST_P1: begin
        p_nxt = qs; ma = bp_r - word_t'(WSIZE); m_wr = 1'b1;
        if (split) begin
          wd = asz | word_t'(32'h1); state_nxt = ST_PS2;
        end else begin
          wd = qs | word_t'(32'h1); state_nxt = ST_PN2;
        end
      end
      ST_PS2: begin
        ma = bp_r + rb_size(bp_r - word_t'(WSIZE), asz | word_t'(32'h1))
             - word_t'(DSIZE);
        wd = asz | word_t'(32'h1); m_wr = 1'b1; state_nxt = ST_PS3;
      end
      ST_PS3: begin
        t_nxt = bp_r + rb_size(bp_r - word_t'(WSIZE), asz | word_t'(32'h1));
        ma = t_nxt - word_t'(WSIZE); wd = csub; m_wr = 1'b1;
        state_nxt = ST_PS4;
      end
      ST_PS4: begin
        ma = t_r + rb_size(t_r - word_t'(WSIZE), csub) - word_t'(DSIZE);
        wd = csub; m_wr = 1'b1; state_nxt = ST_DONE;
      end
      ST_PN2: begin
        ma = bp_r + rb_size(bp_r - word_t'(WSIZE), p_r | word_t'(32'h1))
             - word_t'(DSIZE);
        wd = p_r | word_t'(32'h1); m_wr = 1'b1; state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1; out_addr_nxt = res_addr_r; out_ok_nxt = res_ok_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_oob_nxt = rd_oob_r;
    if (m_rd) rd_oob_nxt = is_oob(ma);
    if (state_r == ST_CLEAR) begin
      mreq.en = 1'b1; mreq.we = 1'b1; mreq.addr = clr_r; mreq.wdata = init_word(clr_r);
    end else begin
      mreq.en    = (m_rd || m_wr) && !is_oob(ma);
      mreq.we    = m_wr;
      mreq.addr  = ma[AW+1:2];
      mreq.wdata = wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rov_r       <= word_t'(LIST_START);
      top_r       <= TOPW'(LIST_START + DSIZE + CHUNK_BYTES);
      out_valid_r <= 1'b0;
      grow_r      <= 1'b0;
      rd_oob_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rov_r       <= rov_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
      grow_r      <= grow_nxt;
      rd_oob_r    <= rd_oob_nxt;
    end
    bp_r <= bp_nxt; p_r <= p_nxt; t_r <= t_nxt; sz_r <= sz_nxt;
    bsz_r <= bsz_nxt; ps_r <= ps_nxt; asz_r <= asz_nxt; n_r <= n_nxt;
    pa_r <= pa_nxt; res_addr_r <= res_addr_nxt; res_ok_r <= res_ok_nxt;
    out_addr_r <= out_addr_nxt; out_ok_r <= out_ok_nxt;
  end

endmodule

FILE: test/implicit_list_next_fit_allocator_chk.sv
// ----------------------------------------------------------------------------
// implicit_list_next_fit_allocator_chk
// Watches both channels, keeps a shadow heap with boundary tags and next-fit
// rover, predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------
package ilnf_tb_pkg;
  typedef enum logic {MODE_ALLOC = 1'b0, MODE_FREE = 1'b1} req_mode_e;
endpackage

module implicit_list_next_fit_allocator_chk
  import ilnf_pkg::*;
  import ilnf_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_block_addr,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_payload_addr,
  input  logic        out_ok,
  output int          errors,
  output int          outstanding
);

  typedef struct {
    logic [15:0] addr;
    logic        ok;
  } grant_t;

  logic [31:0] heap [WORDS];
  logic [31:0] rover, heap_top, list_start;
  grant_t      grants_due[$];

  assign outstanding = grants_due.size();

  function automatic logic [31:0] rd(logic [31:0] a);
    logic [31:0] i;
    i = a >> 2;
    return (i < WORDS) ? heap[i] : 32'd0;
  endfunction

  function automatic void wr(logic [31:0] a, logic [31:0] v);
    logic [31:0] i;
    i = a >> 2;
    if (i < WORDS) heap[i] = v;
  endfunction

  function automatic logic [31:0] sz_at(logic [31:0] a);
    return rd(a) & ~32'd7;
  endfunction

  function automatic logic used_at(logic [31:0] a);
    logic [31:0] v;
    v = rd(a);
    return v[0];
  endfunction

  function automatic logic [31:0] ftr(logic [31:0] bp);
    return bp + sz_at(bp - 4) - 8;
  endfunction

  function automatic logic [31:0] nxt(logic [31:0] bp);
    return bp + sz_at(bp - 4);
  endfunction

  function automatic logic [31:0] prv(logic [31:0] bp);
    return bp - sz_at(bp - 8);
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] bp);
    logic        pa, na;
    logic [31:0] sz;
    pa = used_at(ftr(prv(bp)));
    na = used_at(nxt(bp) - 4);
    sz = sz_at(bp - 4);
    if (pa && !na) begin
      sz += sz_at(nxt(bp) - 4);
      wr(bp - 4, sz);
      wr(ftr(bp), sz);
    end else if (!pa && na) begin
      sz += sz_at(prv(bp) - 4);
      wr(ftr(bp), sz);
      wr(prv(bp) - 4, sz);
      bp = prv(bp);
    end else if (!pa && !na) begin
      sz += sz_at(prv(bp) - 4) + sz_at(ftr(nxt(bp)));
      wr(prv(bp) - 4, sz);
      wr(ftr(nxt(bp)), sz);
      bp = prv(bp);
    end
    rover = bp;
    return bp;
  endfunction

  function automatic logic extend(logic [31:0] bytes, output logic [31:0] bp_o);
    logic [31:0] w, sz, bp;
    w = bytes / 4;
    sz = w[0] ? (w + 1) * 4 : w * 4;
    bp = heap_top;
    bp_o = 0;
    if (64'(heap_top) + 64'(sz) > 64'(HEAP_BYTES)) return 1'b0;
    heap_top += sz;
    wr(bp - 4, sz);
    wr(ftr(bp), sz);
    wr(nxt(bp) - 4, 32'd1);
    bp_o = coalesce(bp);
    return 1'b1;
  endfunction

  function automatic logic fits(logic [31:0] bp, logic [31:0] asize);
    return !used_at(bp - 4) && sz_at(bp - 4) >= asize;
  endfunction

  // next-fit: rover to epilogue, then wrap from list start back to rover
  function automatic logic next_fit(logic [31:0] asize, output logic [31:0] bp_o);
    logic [31:0] bp;
    int          n;
    bp_o = 0;
    bp = nxt(rover);
    for (n = 0; n < WALK_LIMIT && sz_at(bp - 4) != 0; n++) begin
      if (fits(bp, asize)) begin
        rover = bp;
        bp_o = bp;
        return 1'b1;
      end
      bp = nxt(bp);
    end
    bp = list_start;
    for (n = 0; n < WALK_LIMIT && bp < rover; n++) begin
      bp = nxt(bp);
      if (sz_at(bp - 4) == 0) break;
      if (fits(bp, asize)) begin
        rover = bp;
        bp_o = bp;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void carve(logic [31:0] bp, logic [31:0] asize);
    logic [31:0] csize;
    csize = sz_at(bp - 4);
    if (csize >= asize && csize - asize >= MIN_BLOCK) begin
      wr(bp - 4, asize | 1);
      wr(ftr(bp), asize | 1);
      bp = nxt(bp);
      wr(bp - 4, csize - asize);
      wr(ftr(bp), csize - asize);
    end else begin
      wr(bp - 4, csize | 1);
      wr(ftr(bp), csize | 1);
    end
  endfunction

  function automatic void heap_init();
    logic [31:0] bp;
    foreach (heap[i]) heap[i] = 32'd0;
    wr(4, 9);
    wr(8, 9);
    wr(12, 1);
    list_start = LIST_START;
    heap_top = 16;
    void'(extend(CHUNK_BYTES, bp));
    rover = list_start;
  endfunction

  function automatic grant_t heap_request(req_mode_e mode, logic [15:0] req,
                                          logic [15:0] addr);
    grant_t      g;
    logic [31:0] asize, bp, a, sz;
    logic        got;
    g.addr = 0;
    g.ok = 1'b0;
    if (mode == MODE_FREE) begin
      a = addr;
      if (a[2:0] == 0 && a >= list_start + 8 && a < heap_top) begin
        sz = sz_at(a - 4);
        wr(a - 4, sz);
        wr(ftr(a), sz);
        void'(coalesce(a));
      end
      g.ok = 1'b1;
      return g;
    end
    if (req == 0) return g;
    asize = (req <= 8) ? MIN_BLOCK : 8 * ((32'(req) + 15) / 8);
    got = next_fit(asize, bp);
    if (!got) got = extend((asize > CHUNK_BYTES) ? asize : CHUNK_BYTES, bp);
    if (!got) return g;
    carve(bp, asize);
    rover = bp;
    g.addr = bp[15:0];
    g.ok = 1'b1;
    return g;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] exp);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      heap_init();
      grants_due.delete();
    end else begin
      // compare before pushing: a request's result is never out in its own cycle
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          report("unexpected result", out_payload_addr, 16'd0);
        end else begin
          g = grants_due.pop_front();
          if (out_payload_addr !== g.addr) report("payload_addr", out_payload_addr, g.addr);
          if (out_ok !== g.ok) report("ok", out_ok, g.ok);
        end
      end
      if (in_valid && in_ready)
        grants_due.push_back(heap_request(req_mode_e'(in_mode), in_req_size,
                                          in_block_addr));
    end
  end

endmodule

FILE: test/implicit_list_next_fit_allocator_tb.sv
// ----------------------------------------------------------------------------
// implicit_list_next_fit_allocator_tb
// Drives allocate and free requests with random gaps and back-pressure; the
// checker predicts every result from a shadow heap and counts mismatches.
// ----------------------------------------------------------------------------
module implicit_list_next_fit_allocator_tb;
  import ilnf_tb_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 500;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_mode;
  logic [15:0] in_req_size, in_block_addr;
  logic        out_valid, out_ready, out_ok;
  logic [15:0] out_payload_addr;
  int          errors, outstanding;
  int          idle_cycles;
  int          stall_left;
  logic        quiet;
  logic [15:0] live[$];

  implicit_list_next_fit_allocator dut (.*);

  implicit_list_next_fit_allocator_chk chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_req_size, .in_block_addr,
    .out_valid, .out_ready, .out_payload_addr, .out_ok, .errors, .outstanding
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic issue(req_mode_e mode, logic [15:0] size, logic [15:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = mode;
    in_req_size = size;
    in_block_addr = addr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic free_live();
    int idx;
    idx = $urandom_range(0, live.size() - 1);
    issue(MODE_FREE, 16'($urandom), live[idx]);
    live.delete(idx);
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 64));
    if (r < 90) return 16'($urandom_range(65, 1024));
    if (r < 98) return 16'($urandom_range(1025, 8000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // back-pressure on the result side, with stall-free stretches
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      stall_left <= 0;
      quiet <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (!quiet) begin
        r = $urandom_range(0, 99);
        if (r < 15) stall_left <= $urandom_range(1, 3);
        else if (r < 17) stall_left <= $urandom_range(20, 80);
      end
    end
  end
  assign out_ready = rst_n && stall_left == 0;

  always @(posedge clk) begin
    if (out_valid && out_ready && out_ok && out_payload_addr != 0)
      live.push_back(out_payload_addr);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("implicit_list_next_fit_allocator_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_ALLOC;
    in_req_size = 0;
    in_block_addr = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: size extremes, rounding edges, bad frees, exhaustion
    issue(MODE_ALLOC, 16'd0, 16'hffff);
    issue(MODE_ALLOC, 16'd1, 16'd0);
    issue(MODE_ALLOC, 16'd8, 16'd0);
    issue(MODE_ALLOC, 16'd9, 16'd0);
    issue(MODE_ALLOC, 16'd16, 16'd0);
    issue(MODE_ALLOC, 16'd4081, 16'd0);
    issue(MODE_ALLOC, 16'd4096, 16'd0);
    issue(MODE_ALLOC, 16'hffff, 16'd0);
    issue(MODE_FREE, 16'hffff, 16'hffff);
    issue(MODE_FREE, 16'd0, 16'd0);
    issue(MODE_FREE, 16'd0, 16'd8);
    issue(MODE_FREE, 16'd0, 16'd13);
    issue(MODE_FREE, 16'd0, 16'hfff8);
    while (live.size() == 0) @(negedge clk);
    free_live();
    issue(MODE_ALLOC, 16'd30000, 16'd0);
    issue(MODE_ALLOC, 16'd30000, 16'd0);
    issue(MODE_ALLOC, 16'd8000, 16'd0);
    for (int i = 0; i < 6; i++) begin
      if (live.size() > 0) free_live();
    end
    issue(MODE_ALLOC, 16'd24, 16'd0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55 || live.size() == 0 && r < 90) begin
        issue(MODE_ALLOC, pick_size(), 16'($urandom));
      end else if (r < 90) begin
        free_live();
      end else if (r < 95) begin
        issue(MODE_FREE, 16'($urandom), 16'($urandom) | 16'($urandom_range(1, 7)));
      end else begin
        issue(MODE_FREE, 16'($urandom), 16'($urandom_range(0, 1)) << 3);
      end
    end
    // frees of blocks that are no live payload, left for the very end
    issue(MODE_FREE, 16'd0, 16'd24);
    issue(MODE_FREE, 16'd0, 16'd4104);
    issue(MODE_ALLOC, 16'd40, 16'd0);
    in_valid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("implicit_list_next_fit_allocator_tb: done, clean");
    end else begin
      $display("implicit_list_next_fit_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ilnf_pkg.sv
hdl/ilnf_ram.sv
hdl/ilnf_ctrl.sv
hdl/implicit_list_next_fit_allocator.sv
test/implicit_list_next_fit_allocator_chk.sv
test/implicit_list_next_fit_allocator_tb.sv
